>>> design/gha_pkg.sv
`default_nettype none

package gha_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int CAP_W = 9;
    localparam int CAP_RESET = 256;
    localparam int GEN_W = 8;
    localparam int GEN_POS = 24;
    localparam int IDX_W = 24;
    localparam int HANDLE_W = 32;
    localparam int SIDX_W = 8;
    localparam int LIVE_W = 9;
    localparam logic [LIVE_W-1:0] LIVE_MAX = 9'h1FF;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_FREE   = 2'd2,
        KIND_RESET  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RD_HEAD   = 2'd0,
        RD_HANDLE = 2'd1,
        RD_ZERO   = 2'd2,
        RD_NEXT   = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    capture;
        logic    wr_init;
        logic    wr_walk;
        logic    exec;
        kind_t   op;
        logic    cnt_inc;
        logic    cnt_clr;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic walk_last;
    } sts_t;

    function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        begin
            n = g + 8'd1;
            next_gen = (n == 8'd0) ? 8'd1 : n;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/gha_ctrl.sv
`default_nettype none

module gha_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire logic [1:0]    kind,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire gha_pkg::sts_t sts,
    output gha_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_EXEC
    } state_t;

    state_t         state_reg, state_next;
    gha_pkg::kind_t kind_reg, kind_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_free;
    gha_pkg::kind_t req_kind;

    assign req_kind  = gha_pkg::kind_t'(kind);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cmd            = '0;
        cmd.op         = kind_reg;
        cmd.rd_sel     = gha_pkg::RD_HANDLE;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.wr_init = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.init_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    kind_next   = req_kind;
                    unique case (req_kind)
                        gha_pkg::KIND_ALLOC:  cmd.rd_sel = gha_pkg::RD_HEAD;
                        gha_pkg::KIND_RESET:  cmd.rd_sel = gha_pkg::RD_ZERO;
                        default:              cmd.rd_sel = gha_pkg::RD_HANDLE;
                    endcase
                    state_next = (req_kind == gha_pkg::KIND_RESET) ? S_WALK : S_EXEC;
                end
            end
            S_WALK:
            begin
                // read the next slot while writing back the current one
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = gha_pkg::RD_NEXT;
                cmd.wr_walk = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.walk_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            kind_reg      <= gha_pkg::KIND_ALLOC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/gha_dp.sv
`default_nettype none

module gha_dp #(
    parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [gha_pkg::CAP_W-1:0]     cfg_wdata,
    input  wire logic [gha_pkg::HANDLE_W-1:0]  handle_in,
    input  wire gha_pkg::cmd_t                 cmd,
    output gha_pkg::sts_t                      sts,
    output logic [1:0]                         status,
    output logic [gha_pkg::HANDLE_W-1:0]       handle_out,
    output logic [gha_pkg::SIDX_W-1:0]         slot_index,
    output logic [gha_pkg::LIVE_W-1:0]         alive_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int GW = gha_pkg::GEN_W;
    localparam int EW = GW + 1 + PW;
    localparam int CAP_RST = (SLOTS < gha_pkg::CAP_RESET) ? SLOTS : gha_pkg::CAP_RESET;

    logic [EW-1:0] mem [SLOTS];

    logic [gha_pkg::CAP_W-1:0]    cap_reg;
    logic [PW-1:0]                head_reg, head_next;
    logic [gha_pkg::LIVE_W-1:0]   live_reg, live_next;
    logic [IW-1:0]                cnt_reg;
    logic [EW-1:0]                rd_data_reg;
    logic [gha_pkg::HANDLE_W-1:0] handle_reg;

    logic [1:0]                   status_reg, status_next;
    logic [gha_pkg::HANDLE_W-1:0] hout_reg, hout_next;
    logic [gha_pkg::SIDX_W-1:0]   sidx_reg, sidx_next;
    logic [gha_pkg::LIVE_W-1:0]   alive_reg, alive_next;

    logic [IW-1:0]                rd_addr;
    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic [EW-1:0]                wr_data;
    logic [gha_pkg::CAP_W-1:0]    cap_wr;

    logic [GW-1:0]                rd_gen;
    logic                         rd_used;
    logic [PW-1:0]                rd_next;
    logic [gha_pkg::IDX_W-1:0]    hidx;
    logic [GW-1:0]                hgen;
    logic                         handle_ok;
    logic                         pool_empty;
    logic [PW-1:0]                cnt_link;

    assign rd_gen  = rd_data_reg[EW-1 -: GW];
    assign rd_used = rd_data_reg[PW];
    assign rd_next = rd_data_reg[PW-1:0];
    assign hidx    = handle_reg[gha_pkg::IDX_W-1:0];
    assign hgen    = handle_reg[gha_pkg::GEN_POS +: GW];
    assign cnt_link = PW'(cnt_reg) + PW'(1);

    assign handle_ok = (handle_reg != '0)
                    && (32'(hidx) < 32'(cap_reg))
                    && rd_used
                    && (rd_gen == hgen);
    assign pool_empty = (32'(head_reg) >= 32'(cap_reg));

    assign sts.init_last = (32'(cnt_reg) == 32'(SLOTS - 1));
    assign sts.walk_last = (32'(cnt_reg) == 32'(cap_reg) - 32'd1);

    // clamp capacity to 1..SLOTS as it is written
    always_comb
    begin
        if (cfg_wdata == '0)
            cap_wr = gha_pkg::CAP_W'(1);
        else if (32'(cfg_wdata) > 32'(SLOTS))
            cap_wr = gha_pkg::CAP_W'(SLOTS);
        else
            cap_wr = cfg_wdata;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            gha_pkg::RD_HEAD:   rd_addr = head_reg[IW-1:0];
            gha_pkg::RD_HANDLE: rd_addr = handle_in[IW-1:0];
            gha_pkg::RD_ZERO:   rd_addr = '0;
            gha_pkg::RD_NEXT:   rd_addr = cnt_link[IW-1:0];
            default:            rd_addr = '0;
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        live_next   = live_reg;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg;
        wr_data     = '0;
        status_next = status_reg;
        hout_next   = hout_reg;
        sidx_next   = sidx_reg;
        alive_next  = alive_reg;
        if (cmd.wr_init)
        begin
            wr_en   = 1'b1;
            wr_data = {GW'(1), 1'b0, cnt_link};
        end
        else if (cmd.wr_walk)
        begin
            wr_en   = 1'b1;
            wr_data = {gha_pkg::next_gen(rd_gen), 1'b0, cnt_link};
        end
        else if (cmd.exec)
        begin
            status_next = gha_pkg::ST_OK;
            hout_next   = '0;
            sidx_next   = '0;
            unique case (cmd.op)
                gha_pkg::KIND_ALLOC:
                begin
                    if (pool_empty)
                    begin
                        status_next = gha_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = head_reg[IW-1:0];
                        wr_data   = {rd_gen, 1'b1, rd_next};
                        head_next = rd_next;
                        if (live_reg != gha_pkg::LIVE_MAX)
                            live_next = live_reg + gha_pkg::LIVE_W'(1);
                        hout_next = {rd_gen, gha_pkg::IDX_W'(head_reg)};
                        sidx_next = gha_pkg::SIDX_W'(head_reg);
                    end
                end
                gha_pkg::KIND_LOOKUP:
                begin
                    if (handle_ok)
                        sidx_next = hidx[gha_pkg::SIDX_W-1:0];
                    else
                        status_next = gha_pkg::ST_BAD;
                end
                gha_pkg::KIND_FREE:
                begin
                    if (handle_ok)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = hidx[IW-1:0];
                        wr_data   = {gha_pkg::next_gen(rd_gen), 1'b0, head_reg};
                        head_next = PW'(hidx);
                        if (live_reg != '0)
                            live_next = live_reg - gha_pkg::LIVE_W'(1);
                        sidx_next = hidx[gha_pkg::SIDX_W-1:0];
                    end
                    else
                    begin
                        status_next = gha_pkg::ST_BAD;
                    end
                end
                gha_pkg::KIND_RESET:
                begin
                    head_next = '0;
                    live_next = '0;
                end
                default:
                begin
                    status_next = gha_pkg::ST_OK;
                end
            endcase
            alive_next = live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            handle_reg <= handle_in;
        status_reg <= status_next;
        hout_reg   <= hout_next;
        sidx_reg   <= sidx_next;
        alive_reg  <= alive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= gha_pkg::CAP_W'(CAP_RST);
            head_reg <= '0;
            live_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wen)
                cap_reg <= cap_wr;
            head_reg <= head_next;
            live_reg <= live_next;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + IW'(1);
        end
    end

    assign status      = status_reg;
    assign handle_out  = hout_reg;
    assign slot_index  = sidx_reg;
    assign alive_count = alive_reg;

endmodule

`default_nettype wire

>>> design/generational_handle_allocator.sv
`default_nettype none

// Generational handle allocator over SLOTS slots, each holding an 8-bit
// generation, a used flag and a free-list link in one slot memory with a
// registered read port and a separate write port. Alloc, lookup and free each
// read the slot, then check it (alloc and free also write it back), and the next
// request is taken on the cycle after the result is loaded. A reset-all request
// walks the first capacity slots, one slot per cycle through the same memory ports.
// After rst_n a clearing pass fills the whole slot memory (generation
// 1, unused, link i+1); req_stall stays high during it, while capacity writes
// are taken at any time. A result waits in an output register, so a new request
// is accepted while it is stalled. Capacity writes are meant for idle periods
// and must be followed by a reset-all request.
module generational_handle_allocator #(
    parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [gha_pkg::CAP_W-1:0]     cfg_wdata,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [gha_pkg::HANDLE_W-1:0]  handle_in,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [1:0]                         status,
    output logic [gha_pkg::HANDLE_W-1:0]       handle_out,
    output logic [gha_pkg::SIDX_W-1:0]         slot_index,
    output logic [gha_pkg::LIVE_W-1:0]         alive_count
);

    gha_pkg::cmd_t cmd;
    gha_pkg::sts_t sts;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gha_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .handle_in   (handle_in),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .handle_out  (handle_out),
        .slot_index  (slot_index),
        .alive_count (alive_count)
    );

    // load a result only into a free output register
    a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(rsp_valid && rsp_stall))
        else $error("result loaded over a stalled result");

    // no request taken during the clearing pass
    a_init_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_init |-> req_stall)
        else $error("request accepted during clearing pass");

    // an empty-pool or invalid-handle result carries no handle
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == gha_pkg::ST_EMPTY || status == gha_pkg::ST_BAD))
        |-> (handle_out == '0 && slot_index == '0))
        else $error("failed result carries a handle");

    // a loaded result shows a defined status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.exec) |-> (rsp_valid && status != 2'd3))
        else $error("bad status after result load");

endmodule

`default_nettype wire
